### design/tsc_pkg.sv
package tsc_pkg;

	localparam int TOKEN_W         = 16;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_LT    = 3'd1,
		MODE_MINUS = 3'd2,
		MODE_INT   = 3'd3,
		MODE_FRAC  = 3'd4,
		MODE_IDENT = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		KIND_ARROW  = 3'd0,
		KIND_LPAREN = 3'd1,
		KIND_RPAREN = 3'd2,
		KIND_COMMA  = 3'd3,
		KIND_NUMBER = 3'd4,
		KIND_IDENT  = 3'd5,
		KIND_EOF    = 3'd6,
		KIND_ERROR  = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_ARROW   = 2'd1,
		ERR_DOTS    = 2'd2,
		ERR_BADCHAR = 2'd3
	} err_t;

	typedef struct packed {
		kind_t                kind;
		err_t                 err;
		logic [TOKEN_W-1:0]   line;
		logic [TOKEN_W-1:0]   col;
		logic [TOKEN_W-1:0]   len;
	} tok_t;

	// one scanned character: one or two tokens
	typedef struct packed {
		tok_t t0;
		tok_t t1;
		logic two;
	} q_entry_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

endpackage

### design/tsc_in_if.sv
interface tsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_input;

	modport source(output valid, output char_code, output end_of_input, input ready);
	modport sink(input valid, input char_code, input end_of_input, output ready);
endinterface

### design/tsc_out_if.sv
interface tsc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [1:0]  error_code;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source(
		output valid, output token_kind, output error_code, output token_line,
		output token_column, output token_length, output last_of_run, input ready
	);
	modport sink(
		input valid, input token_kind, input error_code, input token_line,
		input token_column, input token_length, input last_of_run, output ready
	);
endinterface

### design/tsc_front.sv
module tsc_front import tsc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	tsc_in_if.sink        chars,
	input  q_status_t     q_stat,
	output logic          push,
	output q_entry_t      push_entry
);

	mode_t              mode_q;
	logic [TOKEN_W-1:0] line_q;
	logic [TOKEN_W-1:0] col_q;
	logic [TOKEN_W-1:0] plen_q;
	logic               done_q;

	mode_t              m;
	logic [TOKEN_W-1:0] line;
	logic [TOKEN_W-1:0] col;
	logic [TOKEN_W-1:0] plen;
	logic               dn;
	logic [7:0]         c;
	logic               consumed;
	logic               have0;
	logic               two;
	tok_t               t0;
	tok_t               t1;
	logic               ie;
	kind_t              ik;
	err_t               ierr;
	logic [TOKEN_W-1:0] ilen;
	tok_t               p;

	function automatic logic [TOKEN_W-1:0] sat_add(input logic [TOKEN_W-1:0] a,
			input logic [TOKEN_W-1:0] b);
		logic [TOKEN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TOKEN_W] ? {TOKEN_W{1'b1}} : s[TOKEN_W-1:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= 8'h30) && (ch <= 8'h39);
	endfunction

	function automatic logic is_ident(input logic [7:0] ch);
		return is_digit(ch) || ((ch >= 8'h61) && (ch <= 8'h7A)) ||
			((ch >= 8'h41) && (ch <= 8'h5A)) || (ch == CH_UNDER);
	endfunction

	assign chars.ready = !q_stat.full;

	always_comb begin
		c        = chars.end_of_input ? CH_NUL : chars.char_code;
		m        = mode_q;
		line     = line_q;
		col      = col_q;
		plen     = plen_q;
		dn       = done_q;
		consumed = 1'b0;
		have0    = 1'b0;
		two      = 1'b0;
		t0       = '0;
		t1       = '0;
		ie       = 1'b0;
		ik       = KIND_ERROR;
		ierr     = ERR_NONE;
		ilen     = '0;
		p        = '0;

		if (done_q) begin
			t0    = '{KIND_EOF, ERR_NONE, line_q, col_q, '0};
			have0 = 1'b1;
		end else begin
			// close or extend the open token
			unique case (mode_q)
				MODE_LT: begin
					have0 = 1'b1;
					if (c == CH_MINUS) begin
						t0       = '{KIND_ARROW, ERR_NONE, line_q, col_q,
							sat_add(plen_q, TOKEN_W'(1))};
						consumed = 1'b1;
					end else begin
						t0 = '{KIND_ERROR, ERR_ARROW, line_q, col_q, plen_q};
					end
				end
				MODE_MINUS: begin
					if (is_digit(c)) begin
						m        = MODE_INT;
						plen     = sat_add(plen_q, TOKEN_W'(1));
						consumed = 1'b1;
					end else begin
						have0 = 1'b1;
						t0    = '{KIND_ERROR, ERR_BADCHAR, line_q, col_q, plen_q};
					end
				end
				MODE_INT, MODE_FRAC: begin
					if (is_digit(c)) begin
						plen     = sat_add(plen_q, TOKEN_W'(1));
						consumed = 1'b1;
					end else if (c == CH_DOT && mode_q == MODE_INT) begin
						m        = MODE_FRAC;
						plen     = sat_add(plen_q, TOKEN_W'(1));
						consumed = 1'b1;
					end else if (c == CH_DOT) begin
						have0    = 1'b1;
						t0       = '{KIND_ERROR, ERR_DOTS, line_q, col_q,
							sat_add(plen_q, TOKEN_W'(1))};
						consumed = 1'b1;
					end else begin
						have0 = 1'b1;
						t0    = '{KIND_NUMBER, ERR_NONE, line_q, col_q, plen_q};
					end
				end
				MODE_IDENT: begin
					if (is_ident(c) || c == CH_DOT) begin
						plen     = sat_add(plen_q, TOKEN_W'(1));
						consumed = 1'b1;
					end else begin
						have0 = 1'b1;
						t0    = '{KIND_IDENT, ERR_NONE, line_q, col_q, plen_q};
					end
				end
				default: begin
					m    = MODE_IDLE;
					plen = '0;
				end
			endcase

			if (have0) begin
				col  = sat_add(col_q, t0.len);
				plen = '0;
				m    = MODE_IDLE;
			end

			// character not taken by the open token starts fresh
			if (!consumed) begin
				unique case (c)
					CH_LF: begin
						line = sat_add(line, TOKEN_W'(1));
						col  = '0;
					end
					CH_SPACE, CH_CR, CH_TAB: col = sat_add(col, TOKEN_W'(1));
					CH_LPAREN: begin
						ie   = 1'b1;
						ik   = KIND_LPAREN;
						ilen = TOKEN_W'(1);
					end
					CH_RPAREN: begin
						ie   = 1'b1;
						ik   = KIND_RPAREN;
						ilen = TOKEN_W'(1);
					end
					CH_COMMA: begin
						ie   = 1'b1;
						ik   = KIND_COMMA;
						ilen = TOKEN_W'(1);
					end
					CH_LT: begin
						m    = MODE_LT;
						plen = TOKEN_W'(1);
					end
					CH_MINUS: begin
						m    = MODE_MINUS;
						plen = TOKEN_W'(1);
					end
					CH_HASH: begin
						m    = MODE_IDENT;
						plen = TOKEN_W'(1);
					end
					CH_NUL: begin
						ie = 1'b1;
						ik = KIND_EOF;
						dn = 1'b1;
					end
					default: begin
						if (is_digit(c)) begin
							m    = MODE_INT;
							plen = TOKEN_W'(1);
						end else if (is_ident(c)) begin
							m    = MODE_IDENT;
							plen = TOKEN_W'(1);
						end else begin
							ie   = 1'b1;
							ik   = KIND_ERROR;
							ierr = ERR_BADCHAR;
							ilen = TOKEN_W'(1);
						end
					end
				endcase

				if (ie) begin
					p    = '{ik, ierr, line, col, ilen};
					col  = sat_add(col, ilen);
					plen = '0;
					m    = MODE_IDLE;
					if (have0) begin
						t1  = p;
						two = 1'b1;
					end else begin
						t0    = p;
						have0 = 1'b1;
					end
				end
			end
		end
	end

	assign push       = chars.valid && chars.ready && have0;
	assign push_entry = '{t0, t1, two};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= TOKEN_W'(1);
			col_q  <= '0;
			plen_q <= '0;
			done_q <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			mode_q <= m;
			line_q <= line;
			col_q  <= col;
			plen_q <= plen;
			done_q <= dn;
		end
	end

endmodule

### design/tsc_queue.sv
module tsc_queue import tsc_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_entry,
	input  logic      pop,
	output q_entry_t  head,
	output q_status_t q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign q_stat.not_empty = (cnt_q != '0);
	assign q_stat.full      = (cnt_q == CW'(DEPTH));
	assign head             = mem_q[rd_q];
	assign do_push          = push && !q_stat.full;
	assign do_pop           = pop && q_stat.not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

### design/tsc_back.sv
module tsc_back import tsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_entry_t  head,
	input  q_status_t q_stat,
	output logic      pop,
	tsc_out_if.source tokens
);

	tok_t out_tok_q;
	logic out_last_q;
	logic out_valid_q;
	logic phase_q;
	logic load;

	// phase_q set: first token of a pair already sent, second one next
	assign load = q_stat.not_empty && (!out_valid_q || tokens.ready);
	assign pop  = load && (!head.two || phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			phase_q     <= head.two && !phase_q;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_tok_q  <= phase_q ? head.t1 : head.t0;
			out_last_q <= !head.two || phase_q;
		end
	end

	assign tokens.valid        = out_valid_q;
	assign tokens.token_kind   = out_tok_q.kind;
	assign tokens.error_code   = out_tok_q.err;
	assign tokens.token_line   = out_tok_q.line;
	assign tokens.token_column = out_tok_q.col;
	assign tokens.token_length = out_tok_q.len;
	assign tokens.last_of_run  = out_last_q;

endmodule

### design/token_scanner.sv
// Flow: a character's tokens are written to the queue as the character is accepted, then
// loaded into the output register. One character per cycle while the queue is not full;
// one token beat per cycle at the output while the sink is ready, so a character yielding
// two tokens takes an output beat per token, absorbed by the QUEUE_DEPTH-entry queue between scanner and output stage.
// Reset: line 1, column 0, no open token, queue and output register empty.
module token_scanner import tsc_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	tsc_in_if.sink    chars,
	tsc_out_if.source tokens
);

	q_status_t q_stat;
	q_entry_t  push_entry;
	q_entry_t  head;
	logic      push;
	logic      pop;

	tsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	tsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	tsc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.tokens (tokens)
	);

`ifndef SYNTHESIS
	a_err_code_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid |-> ((tokens.token_kind == KIND_ERROR) == (tokens.error_code != ERR_NONE)))
		else $error("error code inconsistent with token kind");

	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.token_kind == KIND_EOF
		|-> tokens.token_length == '0 && tokens.last_of_run)
		else $error("eof token must be last with zero length");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.not_empty && !tokens.valid && !(chars.valid && chars.ready)
		|=> !tokens.valid)
		else $error("output beat without a queued token");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.not_empty && (!tokens.valid || tokens.ready))
		else $error("queue pop while empty or output stalled");
`endif

endmodule

### verif/token_scanner_tb.sv
`timescale 1ns / 1ps

module token_scanner_tb;
	import tsc_pkg::*;

	typedef struct packed {
		kind_t       kind;
		err_t        err;
		logic [15:0] line;
		logic [15:0] col;
		logic [15:0] len;
		logic        last;
	} tok_beat_t;

	// one stimulus beat; typed rows carry their expected tokens inline
	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
		logic       typed;
		logic [1:0] n;
		tok_beat_t  t0;
		tok_beat_t  t1;
	} dir_row_t;

	localparam tok_beat_t NO_TOK = '{KIND_EOF, ERR_NONE, 16'd0, 16'd0, 16'd0, 1'b0};
	localparam int N_DIR = 29;

	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{CH_LPAREN, 1'b0, 1'b1, 2'd1,
			'{KIND_LPAREN, ERR_NONE, 16'd1, 16'd0, 16'd1, 1'b1}, NO_TOK},
		'{CH_RPAREN, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_COMMA, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{8'hFF, 1'b0, 1'b1, 2'd1,
			'{KIND_ERROR, ERR_BADCHAR, 16'd1, 16'd3, 16'd1, 1'b1}, NO_TOK},
		'{CH_LT, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_MINUS, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_SPACE, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_LT, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		// lone '<': error, then the 'x' opens an identifier
		'{"x", 1'b0, 1'b1, 2'd1,
			'{KIND_ERROR, ERR_ARROW, 16'd1, 16'd7, 16'd1, 1'b1}, NO_TOK},
		'{CH_LF, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{"1", 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_DOT, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{"5", 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_DOT, 1'b0, 1'b1, 2'd1,
			'{KIND_ERROR, ERR_DOTS, 16'd2, 16'd0, 16'd4, 1'b1}, NO_TOK},
		'{CH_TAB, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_MINUS, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_LPAREN, 1'b0, 1'b1, 2'd2,
			'{KIND_ERROR, ERR_BADCHAR, 16'd2, 16'd5, 16'd1, 1'b0},
			'{KIND_LPAREN, ERR_NONE, 16'd2, 16'd6, 16'd1, 1'b1}},
		'{CH_HASH, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{"a", 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_DOT, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_UNDER, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_COMMA, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{"9", 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{"0", 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_CR, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{"Z", 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_MINUS, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{"7", 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK},
		'{CH_RPAREN, 1'b0, 1'b0, 2'd0, NO_TOK, NO_TOK}
	};

	logic clk = 1'b0;
	logic arst_n;

	tsc_in_if  chars_if();
	tsc_out_if tokens_if();

	token_scanner dut (
		.clk   (clk),
		.arst_n(arst_n),
		.chars (chars_if),
		.tokens(tokens_if)
	);

	always #4 clk = ~clk;

	// side info that travels with the char beat
	logic       row_typed;
	logic [1:0] row_n;
	tok_beat_t  row_t0;
	tok_beat_t  row_t1;

	tok_beat_t pending_tokens[$];
	int        n_mismatch = 0;
	int        sent_items = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	logic      hold_go = 1'b0;

	// scanner image
	mode_t       lex_mode;
	logic [15:0] lex_line;
	logic [15:0] lex_col;
	logic [15:0] open_len;
	logic        eof_seen;
	tok_beat_t   new_toks [2];
	int          new_cnt;

	function automatic logic [15:0] sat_inc(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
			|| c == CH_UNDER;
	endfunction

	function automatic void put_tok(input kind_t k, input err_t e, input logic [15:0] len);
		new_toks[new_cnt] = '{k, e, lex_line, lex_col, len, 1'b0};
		new_cnt++;
		lex_col = sat_inc(lex_col, len);
		open_len = 16'd0;
		lex_mode = MODE_IDLE;
	endfunction

	// char seen with no token open
	function automatic void lex_fresh(input logic [7:0] c);
		case (c)
			CH_LF: begin
				lex_line = sat_inc(lex_line, 16'd1);
				lex_col = 16'd0;
			end
			CH_SPACE, CH_CR, CH_TAB: lex_col = sat_inc(lex_col, 16'd1);
			CH_LPAREN: put_tok(KIND_LPAREN, ERR_NONE, 16'd1);
			CH_RPAREN: put_tok(KIND_RPAREN, ERR_NONE, 16'd1);
			CH_COMMA: put_tok(KIND_COMMA, ERR_NONE, 16'd1);
			CH_LT: begin
				lex_mode = MODE_LT;
				open_len = 16'd1;
			end
			CH_MINUS: begin
				lex_mode = MODE_MINUS;
				open_len = 16'd1;
			end
			CH_HASH: begin
				lex_mode = MODE_IDENT;
				open_len = 16'd1;
			end
			CH_NUL: begin
				put_tok(KIND_EOF, ERR_NONE, 16'd0);
				eof_seen = 1'b1;
			end
			default: begin
				if (is_digit(c)) begin
					lex_mode = MODE_INT;
					open_len = 16'd1;
				end else if (is_word(c)) begin
					lex_mode = MODE_IDENT;
					open_len = 16'd1;
				end else begin
					put_tok(KIND_ERROR, ERR_BADCHAR, 16'd1);
				end
			end
		endcase
	endfunction

	function automatic void lex_char(input logic [7:0] c, input logic e);
		logic [7:0] ch;
		logic       taken;
		ch = e ? CH_NUL : c;
		taken = 1'b0;
		new_cnt = 0;
		if (eof_seen) begin
			put_tok(KIND_EOF, ERR_NONE, 16'd0);
		end else begin
			case (lex_mode)
				MODE_LT: begin
					if (ch == CH_MINUS) begin
						put_tok(KIND_ARROW, ERR_NONE, sat_inc(open_len, 16'd1));
						taken = 1'b1;
					end else begin
						put_tok(KIND_ERROR, ERR_ARROW, open_len);
					end
				end
				MODE_MINUS: begin
					if (is_digit(ch)) begin
						lex_mode = MODE_INT;
						open_len = sat_inc(open_len, 16'd1);
						taken = 1'b1;
					end else begin
						put_tok(KIND_ERROR, ERR_BADCHAR, open_len);
					end
				end
				MODE_INT, MODE_FRAC: begin
					if (is_digit(ch)) begin
						open_len = sat_inc(open_len, 16'd1);
						taken = 1'b1;
					end else if (ch == CH_DOT && lex_mode == MODE_INT) begin
						lex_mode = MODE_FRAC;
						open_len = sat_inc(open_len, 16'd1);
						taken = 1'b1;
					end else if (ch == CH_DOT) begin
						// second dot is swallowed into the error
						put_tok(KIND_ERROR, ERR_DOTS, sat_inc(open_len, 16'd1));
						taken = 1'b1;
					end else begin
						put_tok(KIND_NUMBER, ERR_NONE, open_len);
					end
				end
				MODE_IDENT: begin
					if (is_word(ch) || ch == CH_DOT) begin
						open_len = sat_inc(open_len, 16'd1);
						taken = 1'b1;
					end else begin
						put_tok(KIND_IDENT, ERR_NONE, open_len);
					end
				end
				default: begin
					lex_mode = MODE_IDLE;
					open_len = 16'd0;
				end
			endcase
			if (!taken)
				lex_fresh(ch);
		end
		if (new_cnt > 0)
			new_toks[new_cnt-1].last = 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			n_mismatch++;
			if (n_mismatch <= 200)
				$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		tok_beat_t want;
		if (!arst_n) begin
			lex_mode = MODE_IDLE;
			lex_line = 16'd1;
			lex_col = 16'd0;
			open_len = 16'd0;
			eof_seen = 1'b0;
		end else begin
			if (chars_if.valid && chars_if.ready) begin
				lex_char(chars_if.char_code, chars_if.end_of_input);
				if (row_typed) begin
					pending_tokens = {pending_tokens, row_t0};
					if (row_n == 2'd2)
						pending_tokens = {pending_tokens, row_t1};
				end else begin
					for (int i = 0; i < new_cnt; i++)
						pending_tokens = {pending_tokens, new_toks[i]};
				end
			end
			if (tokens_if.valid && tokens_if.ready) begin
				if (pending_tokens.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 200)
						$error("token beat with none expected: kind %0d line %0d col %0d",
							tokens_if.token_kind, tokens_if.token_line,
							tokens_if.token_column);
				end else begin
					want = pending_tokens.pop_front();
					check_field("token_kind", 16'(want.kind), 16'(tokens_if.token_kind));
					check_field("error_code", 16'(want.err), 16'(tokens_if.error_code));
					check_field("token_line", want.line, tokens_if.token_line);
					check_field("token_column", want.col, tokens_if.token_column);
					check_field("token_length", want.len, tokens_if.token_length);
					check_field("last_of_run", 16'(want.last), 16'(tokens_if.last_of_run));
				end
			end
		end
	end

	// token sink: random stalls plus one long hold-off on request
	initial begin
		int hold_left;
		logic hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		tokens_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_left = 64;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				tokens_if.ready <= 1'b0;
				hold_left--;
			end else begin
				tokens_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_row(input dir_row_t r);
		chars_if.valid <= 1'b1;
		chars_if.char_code <= r.ch;
		chars_if.end_of_input <= r.eoi;
		row_typed <= r.typed;
		row_n <= r.n;
		row_t0 <= r.t0;
		row_t1 <= r.t1;
		sent_items++;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_plain(input logic [7:0] c, input logic e = 1'b0);
		send_row('{c, e, 1'b0, 2'd0, NO_TOK, NO_TOK});
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return 8'("a" + $urandom_range(0, 25));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	// mostly well-formed lexemes, some junk and broken ones
	task automatic random_fragment();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			case ($urandom_range(0, 3))
				0: send_plain(CH_SPACE);
				1: send_plain(CH_TAB);
				2: send_plain(CH_CR);
				default: send_plain(CH_LF);
			endcase
		end else if (pick < 24) begin
			case ($urandom_range(0, 2))
				0: send_plain(CH_LPAREN);
				1: send_plain(CH_RPAREN);
				default: send_plain(CH_COMMA);
			endcase
		end else if (pick < 32) begin
			send_plain(CH_LT);
			send_plain(CH_MINUS);
		end else if (pick < 55) begin
			if ($urandom_range(0, 2) == 0)
				send_plain(CH_MINUS);
			n = $urandom_range(1, 4);
			repeat (n) send_plain(rand_digit());
			if ($urandom_range(0, 1)) begin
				send_plain(CH_DOT);
				n = $urandom_range(0, 3);
				repeat (n) send_plain(rand_digit());
			end
		end else if (pick < 80) begin
			case ($urandom_range(0, 3))
				0: send_plain(CH_HASH);
				1: send_plain(CH_UNDER);
				default: send_plain(rand_letter());
			endcase
			n = $urandom_range(0, 5);
			repeat (n) begin
				case ($urandom_range(0, 4))
					0: send_plain(rand_digit());
					1: send_plain(CH_UNDER);
					2: send_plain(CH_DOT);
					default: send_plain(rand_letter());
				endcase
			end
		end else begin
			case ($urandom_range(0, 4))
				0: send_plain(8'($urandom_range(1, 255)));
				1: send_plain(CH_LT);
				2: send_plain(CH_MINUS);
				3: begin
					send_plain(rand_digit());
					send_plain(CH_DOT);
					send_plain(rand_digit());
					send_plain(CH_DOT);
					send_plain(rand_digit());
				end
				default: begin
					send_plain(CH_MINUS);
					send_plain(rand_letter());
				end
			endcase
		end
	endtask

	initial begin
		int idle_tab [4];
		int stall_tab [4];
		int start;
		idle_tab = '{0, 81, 0, 35};
		stall_tab = '{0, 0, 81, 35};
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.char_code = 8'd0;
		chars_if.end_of_input = 1'b0;
		row_typed = 1'b0;
		row_n = 2'd0;
		row_t0 = NO_TOK;
		row_t1 = NO_TOK;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_row(DIR_ROWS[i]);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_tab[p];
			recv_stall_pct <= stall_tab[p];
			// sink blocks for a while so the input side backs up
			if (p == 0)
				hold_go <= 1'b1;
			start = sent_items;
			while (sent_items - start < 180)
				random_fragment();
		end

		send_idle_pct = 35;
		recv_stall_pct <= 35;
		repeat (20) random_fragment();

		// flush a pending '<' through end marker; char is ignored there
		send_plain(CH_LT);
		send_plain("A", 1'b1);
		send_plain(CH_NUL);
		repeat (6) send_plain(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		chars_if.valid <= 1'b0;

		for (int i = 0; i < 50000 && pending_tokens.size() != 0; i++)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (pending_tokens.size() != 0) begin
			n_mismatch++;
			$error("%0d token beats never arrived", pending_tokens.size());
		end
		if (n_mismatch == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
